/* src/has160_hash_stream_assert.svh */
// Assertion helpers for the HAS-160 stream block.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef HAS160_HASH_STREAM_ASSERT_SVH
`define HAS160_HASH_STREAM_ASSERT_SVH

// Check a condition at every rising clock edge outside reset.
`define HS_ASSERT_COMB(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define HS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/h160_pkg.sv */
package h160_pkg;

	// Working variables of the compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} abcde_t;

	localparam int CHAIN_WORDS = 5;
	localparam int BLOCK_WORDS = 16;
	localparam int EXP_WORDS   = 4;
	localparam int ROUND_STEPS = 20;
	localparam int STEPS       = 80;

	localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] ROUND_K [4] = '{
		32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc
	};

	localparam logic [4:0] ROT_A [ROUND_STEPS] = '{
		5'd5, 5'd11, 5'd7, 5'd15, 5'd6, 5'd13, 5'd8, 5'd14, 5'd7, 5'd12,
		5'd9, 5'd11, 5'd8, 5'd15, 5'd6, 5'd12, 5'd9, 5'd14, 5'd5, 5'd13
	};

	localparam logic [4:0] ROT_B [4] = '{5'd10, 5'd17, 5'd25, 5'd30};

	// Word schedule: 0..15 are block words, 16..19 the expanded words
	localparam logic [4:0] WORD_SEL [STEPS] = '{
		5'd18, 5'd0,  5'd1,  5'd2,  5'd3,  5'd19, 5'd4,  5'd5,  5'd6,  5'd7,
		5'd16, 5'd8,  5'd9,  5'd10, 5'd11, 5'd17, 5'd12, 5'd13, 5'd14, 5'd15,
		5'd18, 5'd3,  5'd6,  5'd9,  5'd12, 5'd19, 5'd15, 5'd2,  5'd5,  5'd8,
		5'd16, 5'd11, 5'd14, 5'd1,  5'd4,  5'd17, 5'd7,  5'd10, 5'd13, 5'd0,
		5'd18, 5'd12, 5'd5,  5'd14, 5'd7,  5'd19, 5'd0,  5'd9,  5'd2,  5'd11,
		5'd16, 5'd4,  5'd13, 5'd6,  5'd15, 5'd17, 5'd8,  5'd1,  5'd10, 5'd3,
		5'd18, 5'd7,  5'd2,  5'd13, 5'd8,  5'd19, 5'd3,  5'd14, 5'd9,  5'd4,
		5'd16, 5'd15, 5'd10, 5'd5,  5'd0,  5'd17, 5'd11, 5'd6,  5'd1,  5'd12
	};

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] dbl;
		dbl = {x, x} << n;
		return dbl[63:32];
	endfunction

endpackage

/* src/h160_in_if.sv */
interface h160_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last;

	modport source (output valid, output data_byte, output byte_present, output last,
		input ready);
	modport sink (input valid, input data_byte, input byte_present, input last,
		output ready);
endinterface

/* src/h160_out_if.sv */
interface h160_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] digest_byte;
	logic       digest_last;

	modport source (output valid, output digest_byte, output digest_last, input ready);
	modport sink (input valid, input digest_byte, input digest_last, output ready);
endinterface

/* src/has160_hash_stream.sv */
// HAS-160 digest over a byte stream, one compression step per cycle while stepping.
// A byte is taken while idle; a byte that completes a 64-byte block starts a compression
// (load, 4 rounds of expanding four words then 20 steps, feed-forward).
// A last item adds a pad state and one or two compressions, then 20 output bytes.
// No input is taken while compressing or sending the digest; a single step unit is shared.
// Reset: chaining words load the initial values, byte count clears, block store is not cleared.
module has160_hash_stream (
	input logic        clk,
	input logic        arst_n,
	h160_in_if.sink    msg,
	h160_out_if.source digest
);

	`include "has160_hash_stream_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_EXP, ST_STEP, ST_FEED, ST_PAD, ST_OUT
	} state_t;

	// What follows the compression in progress
	typedef enum logic [1:0] {
		PH_DATA, PH_PAD, PH_LEN, PH_FIN
	} phase_t;

	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [4:0] LAST_STEP = 5'd19;
	localparam logic [4:0] LAST_OUT  = 5'd19;
	localparam logic [2:0] SUB_FIRST = 3'd1;
	localparam logic [2:0] SUB_LAST  = 3'd4;
	localparam logic [1:0] LAST_RND  = 2'd3;
	localparam logic [1:0] LAST_GRP  = 2'd3;

	state_t           state_q;
	phase_t           phase_q;
	logic [31:0]      chain_q [h160_pkg::CHAIN_WORDS];
	logic [63:0]      cnt_q;
	logic [31:0]      blk_q [h160_pkg::BLOCK_WORDS];
	logic [31:0]      exp_q [h160_pkg::EXP_WORDS];
	logic [31:0]      acc_q;
	h160_pkg::abcde_t work_q;
	h160_pkg::abcde_t work_nxt;
	logic [1:0]       rnd_q;
	logic [4:0]       sidx_q;
	logic [1:0]       grp_q;
	logic [2:0]       sub_q;
	logic [4:0]       oidx_q;

	logic        msg_xfer;
	logic        digest_xfer;
	logic [5:0]  pos;
	logic [63:0] bits;
	logic [6:0]  base;
	logic [6:0]  rd_pos;
	logic [4:0]  sel;
	logic [31:0] w;
	logic [31:0] out_word;

	assign msg.ready   = (state_q == ST_IDLE);
	assign msg_xfer    = msg.valid && msg.ready;
	assign digest_xfer = digest.valid && digest.ready;
	assign pos         = cnt_q[5:0];
	assign bits        = {cnt_q[60:0], 3'b000};

	// Fetch the schedule word for the current expansion or step cycle
	assign base   = 7'(7'(rnd_q) * 7'd20);
	assign rd_pos = (state_q == ST_EXP) ? (base + 7'(7'(grp_q) * 7'd5) + 7'(sub_q))
		: (base + 7'(sidx_q));
	assign sel    = h160_pkg::WORD_SEL[rd_pos];
	assign w      = sel[4] ? exp_q[sel[1:0]] : blk_q[sel[3:0]];

	h160_step u_step (
		.cur  (work_q),
		.w    (w),
		.rnd  (rnd_q),
		.sidx (sidx_q),
		.nxt  (work_nxt)
	);

	// Present the digest byte by byte, low byte of each word first
	assign out_word           = chain_q[oidx_q[4:2]];
	assign digest.valid       = (state_q == ST_OUT);
	assign digest.digest_byte = out_word[{oidx_q[1:0], 3'b000} +: 8];
	assign digest.digest_last = (oidx_q == LAST_OUT);

	// Datapath: block store, expansion words, working variables
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (msg_xfer && msg.byte_present)
					blk_q[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= msg.data_byte;
			end
			ST_LOAD: begin
				work_q <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
			end
			ST_EXP: begin
				if (sub_q == SUB_FIRST)
					acc_q <= w;
				else
					acc_q <= acc_q ^ w;
				if (sub_q == SUB_LAST)
					exp_q[grp_q] <= acc_q ^ w;
			end
			ST_STEP: begin
				work_q <= work_nxt;
			end
			ST_FEED: begin
				// Length-only block after a pad that ran past byte 55
				if (phase_q == PH_LEN) begin
					for (int i = 0; i < h160_pkg::BLOCK_WORDS; i++) begin
						if (i == 14)
							blk_q[i] <= bits[31:0];
						else if (i == 15)
							blk_q[i] <= bits[63:32];
						else
							blk_q[i] <= '0;
					end
				end
			end
			ST_PAD: begin
				// Mark the end with 0x80, zero the rest, put the length in when it fits
				for (int i = 0; i < h160_pkg::BLOCK_WORDS; i++) begin
					for (int j = 0; j < 4; j++) begin
						if (pos < LEN_POS && i == 14)
							blk_q[i][j*8 +: 8] <= bits[j*8 +: 8];
						else if (pos < LEN_POS && i == 15)
							blk_q[i][j*8 +: 8] <= bits[32 + j*8 +: 8];
						else if (6'(i * 4 + j) == pos)
							blk_q[i][j*8 +: 8] <= 8'h80;
						else if (6'(i * 4 + j) > pos)
							blk_q[i][j*8 +: 8] <= 8'h00;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer, chaining words and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_DATA;
			for (int i = 0; i < h160_pkg::CHAIN_WORDS; i++)
				chain_q[i] <= h160_pkg::H_INIT[i];
			cnt_q  <= '0;
			rnd_q  <= '0;
			sidx_q <= '0;
			grp_q  <= '0;
			sub_q  <= SUB_FIRST;
			oidx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (msg_xfer) begin
						if (msg.byte_present)
							cnt_q <= cnt_q + 64'd1;
						if (msg.byte_present && pos == LAST_POS) begin
							phase_q <= msg.last ? PH_PAD : PH_DATA;
							state_q <= ST_LOAD;
						end else if (msg.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					grp_q   <= '0;
					sub_q   <= SUB_FIRST;
					sidx_q  <= '0;
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					if (sub_q == SUB_LAST) begin
						sub_q <= SUB_FIRST;
						if (grp_q == LAST_GRP) begin
							grp_q   <= '0;
							sidx_q  <= '0;
							state_q <= ST_STEP;
						end else begin
							grp_q <= grp_q + 2'd1;
						end
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				ST_STEP: begin
					if (sidx_q == LAST_STEP) begin
						sidx_q <= '0;
						if (rnd_q == LAST_RND) begin
							state_q <= ST_FEED;
						end else begin
							rnd_q   <= rnd_q + 2'd1;
							state_q <= ST_EXP;
						end
					end else begin
						sidx_q <= sidx_q + 5'd1;
					end
				end
				ST_FEED: begin
					chain_q[0] <= chain_q[0] + work_q.a;
					chain_q[1] <= chain_q[1] + work_q.b;
					chain_q[2] <= chain_q[2] + work_q.c;
					chain_q[3] <= chain_q[3] + work_q.d;
					chain_q[4] <= chain_q[4] + work_q.e;
					unique case (phase_q)
						PH_DATA: state_q <= ST_IDLE;
						PH_PAD:  state_q <= ST_PAD;
						PH_LEN: begin
							phase_q <= PH_FIN;
							state_q <= ST_LOAD;
						end
						PH_FIN: begin
							oidx_q  <= '0;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_PAD: begin
					phase_q <= (pos >= LEN_POS) ? PH_LEN : PH_FIN;
					state_q <= ST_LOAD;
				end
				ST_OUT: begin
					if (digest_xfer) begin
						if (oidx_q == LAST_OUT) begin
							// Start a new message
							for (int i = 0; i < h160_pkg::CHAIN_WORDS; i++)
								chain_q[i] <= h160_pkg::H_INIT[i];
							cnt_q   <= '0;
							oidx_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							oidx_q <= oidx_q + 5'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`HS_ASSERT_COMB(a_no_overlap, !(msg.ready && digest.valid),
		"input accepted while digest is pending")
	`HS_ASSERT_NEXT(a_last_busy, msg_xfer && msg.last, !msg.ready,
		"block ready again right after a last item")
	`HS_ASSERT_NEXT(a_restart, digest_xfer && digest.digest_last,
		(cnt_q == '0) && (chain_q[0] == h160_pkg::H_INIT[0]) && (state_q == ST_IDLE),
		"state not returned to initial values after digest")

endmodule

/* src/h160_step.sv */
module h160_step (
	input  h160_pkg::abcde_t cur,
	input  logic [31:0]      w,
	input  logic [1:0]       rnd,
	input  logic [4:0]       sidx,
	output h160_pkg::abcde_t nxt
);

	logic [31:0] f;
	logic [31:0] t;

	// Select the boolean function of the round
	always_comb begin
		unique case (rnd)
			2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
			2'd2: f = cur.c ^ (cur.b | ~cur.d);
			default: f = cur.b ^ cur.c ^ cur.d;
		endcase
	end

	assign t = h160_pkg::rotl32(cur.a, h160_pkg::ROT_A[sidx]) + f + cur.e + w
		+ h160_pkg::ROUND_K[rnd];

	// Shift the working variables
	assign nxt.a = t;
	assign nxt.b = cur.a;
	assign nxt.c = h160_pkg::rotl32(cur.b, h160_pkg::ROT_B[rnd]);
	assign nxt.d = cur.c;
	assign nxt.e = cur.d;

endmodule

/* test/tb_has160_hash_stream.sv */
module tb_has160_hash_stream;
	timeunit 1ns;
	timeprecision 1ps;

	// Step word schedule: 0..15 block words, 16..19 expanded words
	localparam logic [4:0] STEP_WORD [80] = '{
		5'd18, 5'd0,  5'd1,  5'd2,  5'd3,  5'd19, 5'd4,  5'd5,  5'd6,  5'd7,
		5'd16, 5'd8,  5'd9,  5'd10, 5'd11, 5'd17, 5'd12, 5'd13, 5'd14, 5'd15,
		5'd18, 5'd3,  5'd6,  5'd9,  5'd12, 5'd19, 5'd15, 5'd2,  5'd5,  5'd8,
		5'd16, 5'd11, 5'd14, 5'd1,  5'd4,  5'd17, 5'd7,  5'd10, 5'd13, 5'd0,
		5'd18, 5'd12, 5'd5,  5'd14, 5'd7,  5'd19, 5'd0,  5'd9,  5'd2,  5'd11,
		5'd16, 5'd4,  5'd13, 5'd6,  5'd15, 5'd17, 5'd8,  5'd1,  5'd10, 5'd3,
		5'd18, 5'd7,  5'd2,  5'd13, 5'd8,  5'd19, 5'd3,  5'd14, 5'd9,  5'd4,
		5'd16, 5'd15, 5'd10, 5'd5,  5'd0,  5'd17, 5'd11, 5'd6,  5'd1,  5'd12
	};
	localparam logic [4:0] SHIFT_A [20] = '{
		5'd5, 5'd11, 5'd7, 5'd15, 5'd6, 5'd13, 5'd8, 5'd14, 5'd7, 5'd12,
		5'd9, 5'd11, 5'd8, 5'd15, 5'd6, 5'd12, 5'd9, 5'd14, 5'd5, 5'd13
	};
	localparam logic [4:0] SHIFT_B [4] = '{5'd10, 5'd17, 5'd25, 5'd30};
	localparam logic [31:0] STEP_K [4] = '{
		32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc
	};
	localparam logic [31:0] IV [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       last;
	} msg_item_t;

	typedef struct packed {
		logic [7:0] digest_byte;
		logic       digest_last;
	} digest_item_t;

	logic clk;
	logic arst_n;

	h160_in_if  msg_if ();
	h160_out_if dig_if ();

	has160_hash_stream uut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.digest (dig_if)
	);

	// Pending message items and expected digest bytes
	msg_item_t    byte_q [$];
	digest_item_t digest_exp_q [$];

	// Hash state of the predictor
	logic [31:0] chain_h [5];
	logic [31:0] blk_w [16];
	logic [31:0] ext_w [4];
	logic [63:0] msg_len;

	int  fail_cnt;
	int  send_idle;
	int  recv_idle;
	int  items_added;
	bit  in_taken;
	bit  hold_start;
	bit  hold_done;
	int  hold_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] n);
		if (n == 5'd0)
			return x;
		return (x << n) | (x >> (6'd32 - n));
	endfunction

	function automatic logic [31:0] sched_word(input logic [4:0] idx);
		int i;
		i = idx % 20;
		if (i < 16)
			return blk_w[i];
		return ext_w[i - 16];
	endfunction

	// Run the 80 steps on the current block and fold into the chaining words
	task automatic compress_block();
		logic [31:0] a, b, c, d, e, f, t;
		int base, p;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 4; r++) begin
			base = r * 20;
			for (int q = 0; q < 4; q++) begin
				p = base + q * 5 + 1;
				ext_w[q] = sched_word(STEP_WORD[p]) ^ sched_word(STEP_WORD[p + 1]) ^
					sched_word(STEP_WORD[p + 2]) ^ sched_word(STEP_WORD[p + 3]);
			end
			for (int s = 0; s < 20; s++) begin
				if (r == 0)
					f = (b & c) | (~b & d);
				else if (r == 2)
					f = c ^ (b | ~d);
				else
					f = b ^ c ^ d;
				t = rot_left(a, SHIFT_A[s]) + f + e + sched_word(STEP_WORD[base + s]) +
					STEP_K[r];
				e = d;
				d = c;
				c = rot_left(b, SHIFT_B[r]);
				b = a;
				a = t;
			end
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	task automatic put_block_byte(input int pos, input logic [7:0] v);
		blk_w[(pos >> 2) & 15][(pos & 3) * 8 +: 8] = v;
	endtask

	// Absorb one accepted item; on last, pad, finish and queue the 20 digest bytes
	task automatic predict_digest(input msg_item_t it);
		int pos;
		logic [63:0] bits;
		digest_item_t d;
		if (it.byte_present) begin
			put_block_byte(int'(msg_len[5:0]), it.data_byte);
			msg_len = msg_len + 64'd1;
			if (msg_len[5:0] == 6'd0)
				compress_block();
		end
		if (it.last) begin
			pos = int'(msg_len[5:0]);
			put_block_byte(pos, 8'h80);
			for (int k = pos + 1; k < 64; k++)
				put_block_byte(k, 8'h00);
			// Length does not fit: hash the pad block and start a zero block
			if (pos >= 56) begin
				compress_block();
				for (int k = 0; k < 16; k++)
					blk_w[k] = 32'h0;
			end
			bits = msg_len << 3;
			blk_w[14] = bits[31:0];
			blk_w[15] = bits[63:32];
			compress_block();
			for (int k = 0; k < 20; k++) begin
				d.digest_byte = chain_h[k / 4][(k % 4) * 8 +: 8];
				d.digest_last = (k == 19);
				digest_exp_q.push_back(d);
			end
			for (int k = 0; k < 5; k++)
				chain_h[k] = IV[k];
			msg_len = 64'd0;
		end
	endtask

	task automatic push_item(input logic [7:0] data, input logic present, input logic lst);
		msg_item_t it;
		it.data_byte = data;
		it.byte_present = present;
		it.last = lst;
		byte_q.push_back(it);
		if (present || lst)
			items_added++;
	endtask

	// Queue one message of random bytes, with a few ignored items mixed in
	task automatic queue_message(input int len, input bit empty_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 6)
				push_item(8'($urandom), 1'b0, 1'b0);
			push_item(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
		end
		if (empty_end || len == 0)
			push_item(8'($urandom), 1'b0, 1'b1);
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return $urandom_range(6);
		if (r < 75)
			return $urandom_range(68, 52);
		if (r < 85)
			return $urandom_range(130, 118);
		return $urandom_range(40, 7);
	endfunction

	task automatic queue_random(input int count);
		int len;
		int target;
		target = items_added + count;
		while (items_added < target) begin
			len = pick_len();
			// Clip the last message so the phase stays near its item count
			if (len > target - items_added)
				len = target - items_added;
			queue_message(len, (len == 0) || ($urandom_range(3) == 0));
		end
	endtask

	// Hold the sender until the block has drained every expected byte
	task automatic wait_drained();
		while (byte_q.size() != 0 || msg_if.valid || digest_exp_q.size() != 0)
			@(posedge clk);
	endtask

	// Drive message items at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!msg_if.valid || in_taken) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					msg_item_t it;
					it = byte_q.pop_front();
					msg_if.valid <= 1'b1;
					msg_if.data_byte <= it.data_byte;
					msg_if.byte_present <= it.byte_present;
					msg_if.last <= it.last;
				end else begin
					msg_if.valid <= 1'b0;
				end
			end
		end
	end

	// Drive digest ready, with a long hold-off on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_start && !hold_done) begin
				hold_done <= 1'b1;
				hold_cnt <= HOLD_CYCLES;
				dig_if.ready <= 1'b0;
			end else if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				dig_if.ready <= 1'b0;
			end else begin
				dig_if.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Predict on each input transfer, check each output transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= msg_if.valid && msg_if.ready;
			if (msg_if.valid && msg_if.ready)
				predict_digest({msg_if.data_byte, msg_if.byte_present, msg_if.last});
			if (dig_if.valid && dig_if.ready) begin
				if (digest_exp_q.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected digest transfer, expected none, actual %02h/%0b",
						$time, dig_if.digest_byte, dig_if.digest_last);
				end else begin
					digest_item_t ex;
					ex = digest_exp_q.pop_front();
					if (dig_if.digest_byte !== ex.digest_byte) begin
						fail_cnt++;
						$display("%0t: digest_byte mismatch, expected %02h, actual %02h",
							$time, ex.digest_byte, dig_if.digest_byte);
					end
					if (dig_if.digest_last !== ex.digest_last) begin
						fail_cnt++;
						$display("%0t: digest_last mismatch, expected %0b, actual %0b",
							$time, ex.digest_last, dig_if.digest_last);
					end
				end
			end
		end
	end

	initial begin
		fail_cnt = 0;
		items_added = 0;
		hold_start = 1'b0;
		hold_done = 1'b0;
		hold_cnt = 0;
		in_taken = 1'b0;
		send_idle = 31;
		recv_idle = 73;
		msg_len = 64'd0;
		for (int k = 0; k < 5; k++)
			chain_h[k] = IV[k];
		for (int k = 0; k < 16; k++)
			blk_w[k] = 32'h0;
		for (int k = 0; k < 4; k++)
			ext_w[k] = 32'h0;
		msg_if.valid = 1'b0;
		msg_if.data_byte = 8'h00;
		msg_if.byte_present = 1'b0;
		msg_if.last = 1'b0;
		dig_if.ready = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored item, empty message, single extreme bytes
		push_item(8'hff, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'hff, 1'b1, 1'b1);
		// Two bytes, an ignored item inside, closed by an empty final item
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h5a, 1'b0, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'ha5, 1'b0, 1'b1);
		// Pad boundaries: fits, spills past byte 55, full blocks both ways
		queue_message(55, 1'b0);
		queue_message(56, 1'b0);
		queue_message(64, 1'b0);
		queue_message(64, 1'b1);
		wait_drained();

		items_added = 0;
		queue_random(36);
		wait_drained();

		// Swap the idle rates
		send_idle = 73;
		recv_idle = 31;
		items_added = 0;
		queue_random(36);
		wait_drained();

		// No idling; stall the receiver while short messages pile up
		send_idle = 0;
		recv_idle = 0;
		hold_start = 1'b1;
		queue_message(3, 1'b0);
		queue_message(1, 1'b1);
		items_added = 0;
		queue_random(36);
		wait_drained();

		repeat (300) @(posedge clk);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
